// File: hw/rtl/tat_pkg.sv
// ----------------------------------------------------------------------------
// tat_pkg
// Shared types, widths and helpers for the triangle affine transform unit.
// ----------------------------------------------------------------------------
package tat_pkg;

  // vertex store and field widths
  localparam int VERTEX_COUNT = 3;
  localparam int COORD_W      = 24;
  localparam int FACTOR_W     = 16;
  localparam int INDEX_W      = 2;
  localparam int MODE_W       = 2;
  localparam int FACTOR_FRAC  = 14;

  // internal arithmetic widths
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = DIFF_W + FACTOR_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int QUOT_W = SUM_W - FACTOR_FRAC;
  localparam int WIDE_W = QUOT_W + 1;

  // stream payload widths
  localparam int IN_BITS    = INDEX_W + 6 * COORD_W + 4 * FACTOR_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = 2 * VERTEX_COUNT * COORD_W;

  // operation selector carried on tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD      = 2'd0,
    MODE_TRANSLATE = 2'd1,
    MODE_SCALE     = 2'd2,
    MODE_ROTATE    = 2'd3
  } tat_mode_t;

  // request payload, last member sits in the lowest bits
  typedef struct packed {
    logic signed [FACTOR_W-1:0] sin_value;
    logic signed [FACTOR_W-1:0] cos_value;
    logic signed [FACTOR_W-1:0] factor_y;
    logic signed [FACTOR_W-1:0] factor_x;
    logic signed [COORD_W-1:0]  center_y;
    logic signed [COORD_W-1:0]  center_x;
    logic signed [COORD_W-1:0]  offset_y;
    logic signed [COORD_W-1:0]  offset_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_x;
    logic [INDEX_W-1:0]         vertex_index;
  } tat_in_t;

  // clamp a wide two's complement value to the coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic [WIDE_W-1:0] v);
    logic [WIDE_W-COORD_W:0] top;
    logic [COORD_W-1:0]      res;
    top = v[WIDE_W-1:COORD_W-1];
    if (v[WIDE_W-1] && (top != '1)) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else if (!v[WIDE_W-1] && (top != '0)) begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/triangle_affine_transform_unit.sv
// ----------------------------------------------------------------------------
// triangle_affine_transform_unit
// Holds a triangle in Q15.8 and applies load, translate, scale or rotate.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one request per transfer: the operation on
//   in_tuser and its operands on in_tdata. Each request yields one result on
//   the out_ channel holding all six vertex coordinates after the operation.
//   A request is registered on acceptance and worked, once the result
//   register is free or being emptied, by three vertex units in parallel,
//   whose outputs update the vertex store and the result register
//   together; the result then shows on out_tvalid from the result register.
//   Throughput is one request per cycle while results are taken; it is set
//   by the loop from the vertex store through the vertex units (subtract,
//   multiply, sum, clamp) back into the store, with no register inside it.
//   Reset clears all vertices to zero and empties the request and result
//   registers. When the receiver stalls the result is held, one more
//   request is kept in the request register, and in_tready then drops until
//   the result is taken.
// ----------------------------------------------------------------------------
module triangle_affine_transform_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // vertex_index, coord_x, coord_y, offset_x, offset_y, center_x, center_y,
  // factor_x, factor_y, cos_value, sin_value, zero pad
  input  logic [tat_pkg::IN_DATA_W-1:0]     in_tdata,
  // mode
  input  logic [tat_pkg::MODE_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // v0_x, v0_y, v1_x, v1_y, v2_x, v2_y
  output logic [tat_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import tat_pkg::*;

  logic                       in_valid_r;
  tat_in_t                    in_item_r;
  tat_mode_t                  in_mode_r;
  logic                       out_valid_r;
  logic [OUT_DATA_W-1:0]      out_data_r;
  logic [OUT_DATA_W-1:0]      out_data_nxt;
  logic signed [COORD_W-1:0]  vx_r   [VERTEX_COUNT];
  logic signed [COORD_W-1:0]  vy_r   [VERTEX_COUNT];
  logic signed [COORD_W-1:0]  vx_nxt [VERTEX_COUNT];
  logic signed [COORD_W-1:0]  vy_nxt [VERTEX_COUNT];
  logic                       fire;

  // request is worked when the result register is free or being emptied
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= tat_in_t'(in_tdata[IN_BITS-1:0]);
      in_mode_r <= tat_mode_t'(in_tuser);
    end
  end

  // one unit per vertex
  for (genvar i = 0; i < VERTEX_COUNT; i++) begin : g_vertex
    tat_vertex_unit u_vertex (
      .mode    (in_mode_r),
      .load_en (in_item_r.vertex_index == INDEX_W'(i)),
      .item    (in_item_r),
      .x       (vx_r[i]),
      .y       (vy_r[i]),
      .x_nxt   (vx_nxt[i]),
      .y_nxt   (vy_nxt[i])
    );
    assign out_data_nxt[(2*i)*COORD_W +: COORD_W]   = vx_nxt[i];
    assign out_data_nxt[(2*i+1)*COORD_W +: COORD_W] = vy_nxt[i];
  end

  // vertex store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VERTEX_COUNT; i++) begin
        vx_r[i] <= '0;
        vy_r[i] <= '0;
      end
    end else if (fire) begin
      for (int i = 0; i < VERTEX_COUNT; i++) begin
        vx_r[i] <= vx_nxt[i];
        vy_r[i] <= vy_nxt[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a worked request always leaves a result behind
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("worked request produced no result");

  // a waiting request is kept intact until it is worked
  a_request_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !fire) |=> (in_valid_r && $stable(in_item_r) && $stable(in_mode_r)))
    else $error("pending request lost or changed");

  // a shown result matches the vertex store in v0_x and v2_y
  a_result_matches_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_data_r[COORD_W-1:0] == vx_r[0])
                 && (out_data_r[OUT_DATA_W-1 -: COORD_W] == vy_r[VERTEX_COUNT-1])))
    else $error("result differs from vertex store");

  // no new request is taken while both stages are full and stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("request accepted into a full pipeline");

endmodule

// File: hw/rtl/tat_vertex_unit.sv
// ----------------------------------------------------------------------------
// tat_vertex_unit
// Next coordinates of one vertex for load, translate, scale and rotate.
// ----------------------------------------------------------------------------
module tat_vertex_unit (
  input  tat_pkg::tat_mode_t                 mode,
  input  logic                               load_en,
  input  tat_pkg::tat_in_t                   item,
  input  logic signed [tat_pkg::COORD_W-1:0] x,
  input  logic signed [tat_pkg::COORD_W-1:0] y,
  output logic signed [tat_pkg::COORD_W-1:0] x_nxt,
  output logic signed [tat_pkg::COORD_W-1:0] y_nxt
);
  import tat_pkg::*;

  logic signed [DIFF_W-1:0]   dx;
  logic signed [DIFF_W-1:0]   dy;
  logic signed [FACTOR_W-1:0] fa;
  logic signed [FACTOR_W-1:0] fb;
  logic signed [PROD_W-1:0]   pa;
  logic signed [PROD_W-1:0]   pb;
  logic signed [PROD_W-1:0]   pc;
  logic signed [PROD_W-1:0]   pd;
  logic [SUM_W-1:0]           sx;
  logic [SUM_W-1:0]           sy;
  logic [WIDE_W-1:0]          wx_mul;
  logic [WIDE_W-1:0]          wy_mul;
  logic [WIDE_W-1:0]          wx_add;
  logic [WIDE_W-1:0]          wy_add;
  logic                       is_scale;

  // offsets from the pivot, exact
  assign dx = {x[COORD_W-1], x} - {item.center_x[COORD_W-1], item.center_x};
  assign dy = {y[COORD_W-1], y} - {item.center_y[COORD_W-1], item.center_y};

  // shared multipliers: scale uses the two diagonal products only
  assign is_scale = (mode == MODE_SCALE);
  assign fa = is_scale ? item.factor_x : item.cos_value;
  assign fb = is_scale ? item.factor_y : item.cos_value;
  assign pa = dx * fa;
  assign pb = dy * fb;
  assign pc = dx * item.sin_value;
  assign pd = dy * item.sin_value;

  // exact sums of products
  assign sx = is_scale ? {pa[PROD_W-1], pa}
                       : ({pa[PROD_W-1], pa} - {pd[PROD_W-1], pd});
  assign sy = is_scale ? {pb[PROD_W-1], pb}
                       : ({pc[PROD_W-1], pc} + {pb[PROD_W-1], pb});

  // floor shift by dropping fraction bits, then add the pivot back
  assign wx_mul = {{(WIDE_W-COORD_W){item.center_x[COORD_W-1]}}, item.center_x}
                + {sx[SUM_W-1], sx[SUM_W-1:FACTOR_FRAC]};
  assign wy_mul = {{(WIDE_W-COORD_W){item.center_y[COORD_W-1]}}, item.center_y}
                + {sy[SUM_W-1], sy[SUM_W-1:FACTOR_FRAC]};

  // translation sums
  assign wx_add = {{(WIDE_W-COORD_W){x[COORD_W-1]}}, x}
                + {{(WIDE_W-COORD_W){item.offset_x[COORD_W-1]}}, item.offset_x};
  assign wy_add = {{(WIDE_W-COORD_W){y[COORD_W-1]}}, y}
                + {{(WIDE_W-COORD_W){item.offset_y[COORD_W-1]}}, item.offset_y};

  // select by operation
  always_comb begin
    x_nxt = x;
    y_nxt = y;
    unique case (mode)
      MODE_LOAD: begin
        if (load_en) begin
          x_nxt = item.coord_x;
          y_nxt = item.coord_y;
        end
      end
      MODE_TRANSLATE: begin
        x_nxt = sat_coord(wx_add);
        y_nxt = sat_coord(wy_add);
      end
      MODE_SCALE, MODE_ROTATE: begin
        x_nxt = sat_coord(wx_mul);
        y_nxt = sat_coord(wy_mul);
      end
      default: begin
        x_nxt = x;
        y_nxt = y;
      end
    endcase
  end

endmodule

// File: tb/triangle_affine_transform_unit_tb.sv
// ----------------------------------------------------------------------------
// triangle_affine_transform_unit_tb
// Self-checking bench for the triangle affine transform unit. A queue of
// load, translate, scale and rotate requests is streamed in with bursty
// timing while the result side stalls on its own pattern. A local model of
// the vertex store predicts every result, which is compared field by field.
// ----------------------------------------------------------------------------
module triangle_affine_transform_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tat_pkg::*;

  localparam int     REQ_TARGET = 1650;
  localparam int     RUN_LIMIT  = 300000;
  localparam int     DRAIN      = 20;
  localparam int     PAD_W      = IN_DATA_W - $bits(tat_in_t);
  localparam longint COORD_HI   = 64'sd8388607;
  localparam longint COORD_LO   = -64'sd8388608;

  typedef struct {
    tat_mode_t op;
    tat_in_t   req;
  } xform_req_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [MODE_W-1:0]     in_tuser   = MODE_LOAD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // stimulus and prediction state
  xform_req_t            pending_reqs[$];
  logic [OUT_DATA_W-1:0] expected_triangles[$];
  logic signed [COORD_W-1:0] tri_x[VERTEX_COUNT];
  logic signed [COORD_W-1:0] tri_y[VERTEX_COUNT];
  xform_req_t            offered;
  int                    burst_left = 8;
  int                    gap_left   = 0;
  int                    rx_cycle   = 0;
  int                    rx_style   = 0;
  int                    hold_left  = 0;
  int                    cycle_count = 0;
  int                    mismatches = 0;
  bit                    timed_out;
  string                 coord_names[6] = '{"v0_x", "v0_y", "v1_x", "v1_y", "v2_x", "v2_y"};

  triangle_affine_transform_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // triangle model
  // ---------------------------------------------------------------------------

  function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
    if (v > COORD_HI) begin
      return COORD_HI[COORD_W-1:0];
    end else if (v < COORD_LO) begin
      return COORD_LO[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

  // applies one request to the model triangle and queues the resulting vertices
  function automatic void step_triangle(input tat_mode_t op, input tat_in_t r);
    longint x, y, px, py, dx, dy, fx, fy, cs, sn;
    logic [COORD_W-1:0]    nx, ny;
    logic [OUT_DATA_W-1:0] verts;
    px = longint'($signed(r.center_x));
    py = longint'($signed(r.center_y));
    fx = longint'($signed(r.factor_x));
    fy = longint'($signed(r.factor_y));
    cs = longint'($signed(r.cos_value));
    sn = longint'($signed(r.sin_value));
    for (int i = 0; i < VERTEX_COUNT; i++) begin
      x  = longint'(tri_x[i]);
      y  = longint'(tri_y[i]);
      dx = x - px;
      dy = y - py;
      nx = tri_x[i];
      ny = tri_y[i];
      case (op)
        MODE_LOAD: begin
          if (r.vertex_index == i) begin
            nx = r.coord_x;
            ny = r.coord_y;
          end
        end
        MODE_TRANSLATE: begin
          nx = clamp_coord(x + longint'($signed(r.offset_x)));
          ny = clamp_coord(y + longint'($signed(r.offset_y)));
        end
        MODE_SCALE: begin
          nx = clamp_coord(px + ((dx * fx) >>> FACTOR_FRAC));
          ny = clamp_coord(py + ((dy * fy) >>> FACTOR_FRAC));
        end
        default: begin
          nx = clamp_coord(px + ((dx * cs - dy * sn) >>> FACTOR_FRAC));
          ny = clamp_coord(py + ((dx * sn + dy * cs) >>> FACTOR_FRAC));
        end
      endcase
      tri_x[i] = nx;
      tri_y[i] = ny;
      verts[2*i*COORD_W +: COORD_W]     = nx;
      verts[(2*i+1)*COORD_W +: COORD_W] = ny;
    end
    expected_triangles.push_back(verts);
  endfunction

  // ---------------------------------------------------------------------------
  // request generation
  // ---------------------------------------------------------------------------

  // every field random, used for ignored operands and noise requests
  function automatic tat_in_t noise_fields();
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return tat_in_t'(raw[$bits(tat_in_t)-1:0]);
  endfunction

  // mostly small coordinates so results stay in range, with extremes mixed in
  function automatic logic [COORD_W-1:0] pick_coord();
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      v = $urandom;
    end else if (sel == 1) begin
      v = $urandom_range(0, 1) ? 8388607 : -8388608;
    end else begin
      v = $urandom_range(0, 131071) - 65536;
    end
    return v[COORD_W-1:0];
  endfunction

  // factors near +-1.0 mostly, with extremes and zero
  function automatic logic [FACTOR_W-1:0] pick_factor();
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    case (sel)
      0: v = $urandom;
      1: v = 32767;
      2: v = -32768;
      3: v = 0;
      default: begin
        v = 16384 + $urandom_range(0, 16384) - 8192;
        if ($urandom_range(0, 3) == 0) begin
          v = -v;
        end
      end
    endcase
    return v[FACTOR_W-1:0];
  endfunction

  task automatic queue_req(input tat_mode_t op, input tat_in_t r);
    xform_req_t item;
    item.op  = op;
    item.req = r;
    pending_reqs.push_back(item);
  endtask

  task automatic queue_load(input int idx, input int x, input int y);
    tat_in_t r;
    r = noise_fields();
    r.vertex_index = idx[INDEX_W-1:0];
    r.coord_x = x[COORD_W-1:0];
    r.coord_y = y[COORD_W-1:0];
    queue_req(MODE_LOAD, r);
  endtask

  task automatic queue_translate(input int ox, input int oy);
    tat_in_t r;
    r = noise_fields();
    r.offset_x = ox[COORD_W-1:0];
    r.offset_y = oy[COORD_W-1:0];
    queue_req(MODE_TRANSLATE, r);
  endtask

  task automatic queue_pivot(input tat_mode_t op, input int cx, input int cy,
                             input int a, input int b);
    tat_in_t r;
    r = noise_fields();
    r.center_x = cx[COORD_W-1:0];
    r.center_y = cy[COORD_W-1:0];
    if (op == MODE_SCALE) begin
      r.factor_x = a[FACTOR_W-1:0];
      r.factor_y = b[FACTOR_W-1:0];
    end else begin
      r.cos_value = a[FACTOR_W-1:0];
      r.sin_value = b[FACTOR_W-1:0];
    end
    queue_req(op, r);
  endtask

  // one random transform with operands chosen to keep the triangle alive
  task automatic queue_random_xform();
    tat_in_t r;
    real     ang;
    r = noise_fields();
    r.offset_x = pick_coord();
    r.offset_y = pick_coord();
    r.center_x = pick_coord();
    r.center_y = pick_coord();
    r.factor_x = pick_factor();
    r.factor_y = pick_factor();
    if ($urandom_range(0, 9) < 8) begin
      ang = real'($urandom_range(0, 3599)) * 3.14159265358979 / 1800.0;
      r.cos_value = FACTOR_W'(int'($cos(ang) * 16384.0));
      r.sin_value = FACTOR_W'(int'($sin(ang) * 16384.0));
    end else begin
      r.cos_value = pick_factor();
      r.sin_value = pick_factor();
    end
    queue_req(tat_mode_t'($urandom_range(1, 3)), r);
  endtask

  task automatic build_stimulus();
    int n;
    // extreme vertices, saturating translations, ignored load slot
    queue_load(0, 8388607, 8388607);
    queue_load(1, -8388608, -8388608);
    queue_load(2, 8388607, -8388608);
    queue_translate(8388607, 8388607);
    queue_translate(-8388608, -8388608);
    queue_load(3, 1234, -5678);
    // scaling: identity, extreme factors about extreme pivots, collapse
    queue_pivot(MODE_SCALE, -8388608, 8388607, -32768, 32767);
    queue_load(0, 256, 512);
    queue_load(1, -768, 80);
    queue_load(2, 4096, -2048);
    queue_translate(128, -64);
    queue_pivot(MODE_SCALE, 0, 0, 16384, 16384);
    queue_pivot(MODE_SCALE, 8388607, -8388608, -32768, 32767);
    queue_pivot(MODE_SCALE, 100, -100, 0, 0);
    // rotation: identity, quarter turn, out of range cos and sin, eighth turn
    queue_load(0, -3000, 700);
    queue_load(2, 9000, 9000);
    queue_pivot(MODE_ROTATE, 0, 0, 16384, 0);
    queue_pivot(MODE_ROTATE, 256, 256, 0, 16384);
    queue_pivot(MODE_ROTATE, 8388607, -8388608, -32768, 32767);
    queue_pivot(MODE_ROTATE, -8388608, 8388607, 32767, -32768);
    queue_pivot(MODE_ROTATE, 0, 0, 11585, 11585);

    // random part: mostly well formed load sequences followed by transforms
    while (pending_reqs.size() < REQ_TARGET) begin
      if ($urandom_range(0, 99) < 12) begin
        queue_req(tat_mode_t'($urandom_range(0, 3)), noise_fields());
      end else begin
        for (int i = 0; i < VERTEX_COUNT; i++) begin
          queue_load(($urandom_range(0, 19) == 0) ? 3 : i,
                     $signed(pick_coord()), $signed(pick_coord()));
        end
        n = $urandom_range(2, 8);
        repeat (n) queue_random_xform();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        step_triangle(offered.op, offered.req);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          offered = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {{PAD_W{1'b0}}, offered.req};
          in_tuser  <= offered.op;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            gap_left   = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                       : $urandom_range(1, 16);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side backpressure with long hold-offs
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (rst_n) begin
      rx_cycle = rx_cycle + 1;
      if (rx_cycle % 128 == 0) begin
        rx_style = $urandom_range(0, 3);
      end
      // stall long enough that the block fills and drops in_tready
      if (rx_cycle == 400 || rx_cycle == 2600) begin
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
      end else begin
        case (rx_style)
          0: rdy = 1'b1;
          1: rdy = $urandom_range(0, 1);
          2: rdy = ($urandom_range(0, 3) != 0);
          default: rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
    out_tready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [OUT_DATA_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_triangles.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        mismatches = mismatches + 1;
      end else begin
        want = expected_triangles.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (out_tdata[i*COORD_W +: COORD_W] !== want[i*COORD_W +: COORD_W]) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, coord_names[i],
                     $signed(want[i*COORD_W +: COORD_W]),
                     $signed(out_tdata[i*COORD_W +: COORD_W]));
            mismatches = mismatches + 1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < VERTEX_COUNT; i++) begin
      tri_x[i] = '0;
      tri_y[i] = '0;
    end
    build_stimulus();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // wait for every request to be accepted and every result to arrive
    while (!(pending_reqs.size() == 0 && !in_tvalid && expected_triangles.size() == 0)
           && cycle_count < RUN_LIMIT) begin
      @(posedge clk);
    end
    repeat (DRAIN) @(posedge clk);
    timed_out = (cycle_count >= RUN_LIMIT);
    if (timed_out || mismatches != 0 || expected_triangles.size() != 0) begin
      $display("CHECK FAILED");
    end else begin
      $display("CHECK OK");
    end
    $finish;
  end

endmodule
